[hdl/ptl_pkg.sv]
// ----------------------------------------------------------------------------
// ptl_pkg
// Shared types and codes for the peer table: request layout, result codes,
// the control group that goes to every cell and the record passed along the
// row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ptl_pkg;

	// widest slot index, for a table of up to 64 entries
	localparam int IDX_W = 6;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_FIND     = 2'd1,
		OP_REMOVE   = 2'd2,
		OP_COUNT    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_UPDATED   = 3'd0,
		ST_CREATED   = 3'd1,
		ST_FULL      = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_REMOVED   = 3'd5,
		ST_BAD_INDEX = 3'd6,
		ST_COUNTED   = 3'd7
	} status_t;

	typedef struct packed {
		op_t                operation;
		logic [31:0]        peer_address;
		logic [15:0]        peer_port;
		logic [63:0]        peer_tag;
		logic [31:0]        files_handle;
		logic [7:0]         files_count;
		logic signed [7:0]  slot_request;
	} req_t;

	// broadcast to every cell
	typedef struct packed {
		logic fire;
		logic any_hit;
		logic rm_ok;
	} cell_ctl_t;

	// handed from one cell to the next
	typedef struct packed {
		logic             hit_seen;
		logic [IDX_W-1:0] hit_idx;
		logic             free_seen;
		logic [IDX_W-1:0] free_idx;
		logic             rm_live;
	} chain_t;

endpackage

`default_nettype wire

[hdl/ptl_cell.sv]
// ----------------------------------------------------------------------------
// ptl_cell
// One table entry. Compares its key with the request, takes part in the
// lowest-match and lowest-free priority chain, and updates itself when the
// request completes.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_cell (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [ptl_pkg::IDX_W-1:0] cell_index,
	input  wire ptl_pkg::req_t           req,
	input  wire ptl_pkg::cell_ctl_t      ctl,
	input  wire ptl_pkg::chain_t         chain_in,
	output ptl_pkg::chain_t              chain_out
);

	logic        live_q;
	logic [31:0] address_q;
	logic [15:0] port_q;
	logic [63:0] tag_q;
	logic [31:0] handle_q;
	logic [7:0]  count_q;

	logic key_match;
	logic hit_first;
	logic free_first;
	logic rm_sel;

	assign key_match  = live_q && (address_q == req.peer_address) && (port_q == req.peer_port);
	assign hit_first  = key_match && !chain_in.hit_seen;
	assign free_first = !live_q && !chain_in.free_seen;
	assign rm_sel     = ($unsigned(req.slot_request) == 8'(cell_index));

	always_comb begin
		chain_out.hit_seen  = chain_in.hit_seen | key_match;
		chain_out.hit_idx   = chain_in.hit_seen ? chain_in.hit_idx : cell_index;
		chain_out.free_seen = chain_in.free_seen | !live_q;
		chain_out.free_idx  = chain_in.free_seen ? chain_in.free_idx : cell_index;
		chain_out.rm_live   = chain_in.rm_live | (rm_sel & live_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= 1'b0;
			address_q <= '0;
			port_q    <= '0;
			tag_q     <= '0;
			handle_q  <= '0;
			count_q   <= '0;
		end else if (ctl.fire) begin
			case (req.operation)
				ptl_pkg::OP_REGISTER: begin
					if (hit_first) begin
						handle_q <= req.files_handle;
						if (req.files_count != 8'd0) count_q <= req.files_count;
					end else if (!ctl.any_hit && free_first) begin
						live_q    <= 1'b1;
						address_q <= req.peer_address;
						port_q    <= req.peer_port;
						tag_q     <= req.peer_tag;
						handle_q  <= req.files_handle;
						if (req.files_count != 8'd0) count_q <= req.files_count;
					end
				end
				ptl_pkg::OP_REMOVE: begin
					// only the live mark goes, the rest of the entry stays
					if (ctl.rm_ok && rm_sel) live_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/peer_table_lookup_insert_core.sv]
// ----------------------------------------------------------------------------
// peer_table_lookup_insert_core
// Peer table keyed by address and port: register or update, find, remove
// by slot and count, built as a row of entry cells.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       to core    in_valid/in_ready    operation, peer_address, peer_port,
//                                           peer_tag, files_handle, files_count,
//                                           slot_request
//  out      from core  out_valid/out_ready  status, slot, live_total
//
// An item is first captured in the request register; the cell row then finds
// the lowest match and lowest free slot and commits the update.
// The priority chain across TABLE_ENTRIES cells sets the match cycle's depth.
// Reset clears the whole table at once, no sweep.
// A stalled result holds the captured request, and no new item is taken
// until it moves to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_table_lookup_insert_core #(
	parameter int TABLE_ENTRIES = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        operation,
	input  wire logic [31:0]       peer_address,
	input  wire logic [15:0]       peer_port,
	input  wire logic [63:0]       peer_tag,
	input  wire logic [31:0]       files_handle,
	input  wire logic [7:0]        files_count,
	input  wire logic signed [7:0] slot_request,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             status,
	output logic [3:0]             slot,
	output logic [4:0]             live_total
);

	localparam int LIVE_W = $clog2(TABLE_ENTRIES + 1);

	ptl_pkg::req_t      req_s1;
	logic               valid_s1;
	ptl_pkg::cell_ctl_t ctl;
	ptl_pkg::chain_t    chain [0:TABLE_ENTRIES];

	logic [LIVE_W-1:0]   live_q;
	logic [LIVE_W-1:0]   live_nxt;
	logic [LIVE_W+4:0]   live_ext;
	ptl_pkg::status_t    status_nxt;
	logic [3:0]          slot_nxt;
	logic                fire;

	ptl_pkg::status_t    status_q;
	logic [3:0]          slot_q;
	logic [4:0]          live_total_q;
	logic                out_valid_q;

	assign in_ready = !valid_s1;
	assign fire     = valid_s1 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.operation    <= ptl_pkg::op_t'(operation);
			req_s1.peer_address <= peer_address;
			req_s1.peer_port    <= peer_port;
			req_s1.peer_tag     <= peer_tag;
			req_s1.files_handle <= files_handle;
			req_s1.files_count  <= files_count;
			req_s1.slot_request <= slot_request;
		end
	end

	assign chain[0] = '0;

	always_comb begin
		ctl.fire    = fire;
		ctl.any_hit = chain[TABLE_ENTRIES].hit_seen;
		// negative or past the end is rejected
		ctl.rm_ok   = !req_s1.slot_request[7] &&
			($unsigned(req_s1.slot_request) < 8'(TABLE_ENTRIES));
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		ptl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_index (ptl_pkg::IDX_W'(i)),
			.req        (req_s1),
			.ctl        (ctl),
			.chain_in   (chain[i]),
			.chain_out  (chain[i+1])
		);
	end

	always_comb begin
		live_nxt   = live_q;
		slot_nxt   = 4'd0;
		status_nxt = ptl_pkg::ST_COUNTED;
		case (req_s1.operation)
			ptl_pkg::OP_REGISTER: begin
				if (ctl.any_hit) begin
					status_nxt = ptl_pkg::ST_UPDATED;
					slot_nxt   = chain[TABLE_ENTRIES].hit_idx[3:0];
				end else if (chain[TABLE_ENTRIES].free_seen) begin
					status_nxt = ptl_pkg::ST_CREATED;
					slot_nxt   = chain[TABLE_ENTRIES].free_idx[3:0];
					live_nxt   = live_q + LIVE_W'(1);
				end else begin
					status_nxt = ptl_pkg::ST_FULL;
				end
			end
			ptl_pkg::OP_FIND: begin
				if (ctl.any_hit) begin
					status_nxt = ptl_pkg::ST_FOUND;
					slot_nxt   = chain[TABLE_ENTRIES].hit_idx[3:0];
				end else begin
					status_nxt = ptl_pkg::ST_NOT_FOUND;
				end
			end
			ptl_pkg::OP_REMOVE: begin
				if (ctl.rm_ok) begin
					status_nxt = ptl_pkg::ST_REMOVED;
					slot_nxt   = req_s1.slot_request[3:0];
					// removing a dead slot leaves the count alone
					if (chain[TABLE_ENTRIES].rm_live) live_nxt = live_q - LIVE_W'(1);
				end else begin
					status_nxt = ptl_pkg::ST_BAD_INDEX;
				end
			end
			default: begin
				status_nxt = ptl_pkg::ST_COUNTED;
			end
		endcase
	end

	assign live_ext = (LIVE_W + 5)'(live_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				live_q      <= live_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q     <= status_nxt;
			slot_q       <= slot_nxt;
			live_total_q <= live_ext[4:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot       = slot_q;
	assign live_total = live_total_q;

endmodule

`default_nettype wire

[hdl/ptl_checker.sv]
// ----------------------------------------------------------------------------
// ptl_checker
// Port-level checks on the peer table core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_checker #(
	parameter int TABLE_ENTRIES = 16
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] status,
	input wire logic [3:0] slot,
	input wire logic [4:0] live_total
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot)
			&& $stable(live_total))
		else $error("result changed while stalled");

	// a fresh result always follows an item that went straight through the request and output registers
	a_rose_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching item");

	// one item in flight in the match stage
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in the match stage");

	// slot reads zero for outcomes that name no slot
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ptl_pkg::ST_FULL || status == ptl_pkg::ST_NOT_FOUND ||
			status == ptl_pkg::ST_BAD_INDEX || status == ptl_pkg::ST_COUNTED)
			|-> slot == 4'd0)
		else $error("nonzero slot on a slotless outcome");

	// live count within the table size, and nonzero right after a create
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (TABLE_ENTRIES > 31 || 32'(live_total) <= TABLE_ENTRIES) &&
			(status != ptl_pkg::ST_CREATED || TABLE_ENTRIES > 31 || live_total != 5'd0))
		else $error("live count out of range");

endmodule

bind peer_table_lookup_insert_core ptl_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ptl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.slot       (slot),
	.live_total (live_total)
);

`default_nettype wire
